// ===== design/three_point_axis_scaler_core_macros.svh =====
// Assertion macros for the three-point axis scaler checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef THREE_POINT_AXIS_SCALER_CORE_MACROS_SVH
`define THREE_POINT_AXIS_SCALER_CORE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define TPAS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define TPAS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also runs while reset is asserted.
`define TPAS_ASSERT_RST_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tpas_pkg.sv =====
// Shared types, register codes and the divider step for the axis scaler.
// No dependencies; imported by three_point_axis_scaler_core.
package tpas_pkg;

  localparam int unsigned DATA_W             = 8;
  localparam int unsigned NUM_W              = 16;
  localparam int unsigned DIV_BITS_PER_STAGE = 4;
  localparam int unsigned DIV_STAGES         = NUM_W / DIV_BITS_PER_STAGE;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CAL_LOW    = 3'd0,
    REG_CAL_CENTER = 3'd1,
    REG_CAL_HIGH   = 3'd2,
    REG_OUT_CENTER = 3'd3,
    REG_OUT_MAX    = 3'd4
  } cfg_reg_t;

  localparam logic [DATA_W-1:0] RST_CAL_LOW    = 8'd0;
  localparam logic [DATA_W-1:0] RST_CAL_CENTER = 8'd128;
  localparam logic [DATA_W-1:0] RST_CAL_HIGH   = 8'd255;
  localparam logic [DATA_W-1:0] RST_OUT_CENTER = 8'd128;
  localparam logic [DATA_W-1:0] RST_OUT_MAX    = 8'd255;

  // One word in flight through the divider stages.
  // work holds the remaining dividend bits on top and the quotient bits below.
  typedef struct packed {
    logic [NUM_W-1:0]  work;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] dmag;
    logic              qneg;
    logic [DATA_W-1:0] oc;
    logic [DATA_W-1:0] om;
    logic              err;
    logic              inv;
  } div_word_t;

  // Retire DIV_BITS_PER_STAGE quotient bits by restoring division.
  function automatic div_word_t div_steps(input div_word_t din);
    div_word_t         w;
    logic [DATA_W:0]   trial;
    w = din;
    for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
      trial = {w.rem, w.work[NUM_W-1]};
      if (trial >= {1'b0, w.dmag}) begin
        trial  = trial - {1'b0, w.dmag};
        w.work = {w.work[NUM_W-2:0], 1'b1};
      end else begin
        w.work = {w.work[NUM_W-2:0], 1'b0};
      end
      w.rem = trial[DATA_W-1:0];
    end
    return w;
  endfunction

endpackage

// ===== design/three_point_axis_scaler_core.sv =====
// Three-point piecewise-linear axis calibration, pipelined one word per cycle while not stalled.
// Depends on tpas_pkg (types, register codes, divider step).
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  cfg     | in        | cfg_we              | cfg_index, cfg_wdata
//  in      | in        | in_valid / in_stall | in_raw_sample
//  out     | out       | out_valid/out_stall | out_scaled_value, out_span_error,
//          |           |                     | out_cal_invalid
//
// One word enters per cycle unless in_stall is high; the pipeline stages, in order:
// prepare, multiply, four divider stages of four quotient bits each, clamp/output.
// Each stage moves when it is empty or the stage after it moves, so bubbles close up.
// Reset is synchronous: it empties the pipeline and loads the calibration defaults.
// A held output blocks input only once every stage is full.
module three_point_axis_scaler_core
  import tpas_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [DATA_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [DATA_W-1:0] in_raw_sample,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_scaled_value,
  output logic              out_span_error,
  output logic              out_cal_invalid
);

  typedef struct packed {
    logic [DATA_W:0]   mult;
    logic [DATA_W:0]   offset;
    logic [DATA_W-1:0] dmag;
    logic              dneg;
    logic [DATA_W-1:0] oc;
    logic [DATA_W-1:0] om;
    logic              err;
    logic              inv;
  } prep_word_t;

  localparam int unsigned PROD_W = 2 * (DATA_W + 1);

  // Calibration registers
  logic [DATA_W-1:0] cal_low_r, cal_center_r, cal_high_r, out_center_r, out_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_low_r    <= RST_CAL_LOW;
      cal_center_r <= RST_CAL_CENTER;
      cal_high_r   <= RST_CAL_HIGH;
      out_center_r <= RST_OUT_CENTER;
      out_max_r    <= RST_OUT_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAL_LOW:    cal_low_r    <= cfg_wdata;
        REG_CAL_CENTER: cal_center_r <= cfg_wdata;
        REG_CAL_HIGH:   cal_high_r   <= cfg_wdata;
        REG_OUT_CENTER: out_center_r <= cfg_wdata;
        REG_OUT_MAX:    out_max_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline registers
  logic              a_v_r, b_v_r, out_valid_r;
  logic [DIV_STAGES-1:0] div_v_r;
  prep_word_t        a_r, a_nxt;
  div_word_t         b_r, b_nxt;
  div_word_t         div_r   [DIV_STAGES];
  div_word_t         div_nxt [DIV_STAGES];
  logic [DATA_W-1:0] scaled_r, scaled_nxt;
  logic              err_r, inv_r;

  // Stage enables, from the output back to the input
  logic              out_en, a_en, b_en;
  logic [DIV_STAGES-1:0] div_en;

  always_comb begin
    out_en = !out_valid_r || !out_stall;
    div_en[DIV_STAGES-1] = !div_v_r[DIV_STAGES-1] || out_en;
    for (int k = DIV_STAGES - 2; k >= 0; k--) begin
      div_en[k] = !div_v_r[k] || div_en[k+1];
    end
    b_en = !b_v_r || div_en[0];
    a_en = !a_v_r || b_en;
  end

  assign in_stall = !a_en;

  // Prepare: pick the side, its span and the output swing
  logic signed [DATA_W:0] offset, down_span, up_span, span_sel, span_abs, mult_sel;
  logic                   low_side, at_center, span_zero, force_center, centre_between;

  always_comb begin
    offset    = $signed({1'b0, in_raw_sample}) - $signed({1'b0, cal_center_r});
    down_span = $signed({1'b0, cal_low_r})     - $signed({1'b0, cal_center_r});
    up_span   = $signed({1'b0, cal_high_r})    - $signed({1'b0, cal_center_r});
    low_side  = (offset[DATA_W] == down_span[DATA_W]);
    span_sel  = low_side ? down_span : up_span;
    // low side: oc - oc*off/ls == oc + (-oc)*off/ls with truncation toward zero
    mult_sel  = low_side ? -$signed({1'b0, out_center_r})
                         : $signed({1'b0, out_max_r}) - $signed({1'b0, out_center_r});
    span_abs  = span_sel[DATA_W] ? -span_sel : span_sel;
    at_center    = (offset == '0);
    span_zero    = (span_sel == '0);
    force_center = at_center || span_zero;
    centre_between = (cal_low_r < cal_center_r && cal_center_r < cal_high_r) ||
                     (cal_low_r > cal_center_r && cal_center_r > cal_high_r);

    // forced centre: zero product over a unit divisor gives a zero quotient
    a_nxt.mult   = force_center ? '0 : mult_sel;
    a_nxt.offset = offset;
    a_nxt.dmag   = force_center ? DATA_W'(1) : span_abs[DATA_W-1:0];
    a_nxt.dneg   = span_sel[DATA_W];
    a_nxt.oc     = out_center_r;
    a_nxt.om     = out_max_r;
    a_nxt.err    = !at_center && span_zero;
    a_nxt.inv    = !centre_between;
  end

  // Multiply: signed product, split into magnitude and quotient sign
  logic signed [PROD_W-1:0] prod, prod_abs;

  always_comb begin
    prod     = PROD_W'($signed(a_r.mult)) * PROD_W'($signed(a_r.offset));
    prod_abs = prod[PROD_W-1] ? -prod : prod;
    b_nxt.work = prod_abs[NUM_W-1:0];
    b_nxt.rem  = '0;
    b_nxt.dmag = a_r.dmag;
    b_nxt.qneg = prod[PROD_W-1] ^ a_r.dneg;
    b_nxt.oc   = a_r.oc;
    b_nxt.om   = a_r.om;
    b_nxt.err  = a_r.err;
    b_nxt.inv  = a_r.inv;
  end

  // Divide: four quotient bits per stage
  always_comb begin
    div_nxt[0] = div_steps(b_r);
    for (int k = 1; k < DIV_STAGES; k++) begin
      div_nxt[k] = div_steps(div_r[k-1]);
    end
  end

  // Apply sign, add the output centre, clamp to 0..out_max
  logic [NUM_W-1:0]         quot;
  logic signed [PROD_W-1:0] quot_s, sum_s;
  div_word_t                last_w;

  always_comb begin
    last_w = div_r[DIV_STAGES-1];
    quot   = last_w.work;
    quot_s = $signed({{(PROD_W-NUM_W){1'b0}}, quot});
    if (last_w.qneg) begin
      quot_s = -quot_s;
    end
    sum_s = $signed({{(PROD_W-DATA_W){1'b0}}, last_w.oc}) + quot_s;
    if (sum_s[PROD_W-1]) begin
      scaled_nxt = '0;
    end else if (sum_s > $signed({{(PROD_W-DATA_W){1'b0}}, last_w.om})) begin
      scaled_nxt = last_w.om;
    end else begin
      scaled_nxt = sum_s[DATA_W-1:0];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      div_v_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_en) begin
        a_v_r <= in_valid;
      end
      if (b_en) begin
        b_v_r <= a_v_r;
      end
      if (div_en[0]) begin
        div_v_r[0] <= b_v_r;
      end
      for (int k = 1; k < DIV_STAGES; k++) begin
        if (div_en[k]) begin
          div_v_r[k] <= div_v_r[k-1];
        end
      end
      if (out_en) begin
        out_valid_r <= div_v_r[DIV_STAGES-1];
      end
    end
  end

  // Payload registers: load when the stage advances with a word
  always_ff @(posedge clk) begin
    if (a_en && in_valid) begin
      a_r <= a_nxt;
    end
    if (b_en && a_v_r) begin
      b_r <= b_nxt;
    end
    if (div_en[0] && b_v_r) begin
      div_r[0] <= div_nxt[0];
    end
    for (int k = 1; k < DIV_STAGES; k++) begin
      if (div_en[k] && div_v_r[k-1]) begin
        div_r[k] <= div_nxt[k];
      end
    end
    if (out_en && div_v_r[DIV_STAGES-1]) begin
      scaled_r <= scaled_nxt;
      err_r    <= last_w.err;
      inv_r    <= last_w.inv;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_scaled_value = scaled_r;
  assign out_span_error   = err_r;
  assign out_cal_invalid  = inv_r;

endmodule

// ===== design/tpas_checker.sv =====
// Port-level checks for three_point_axis_scaler_core, bound to the top level.
// Depends on three_point_axis_scaler_core_macros.svh.
`include "three_point_axis_scaler_core_macros.svh"

module tpas_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       cfg_we,
  input logic [2:0] cfg_index,
  input logic [7:0] cfg_wdata,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_raw_sample,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_scaled_value,
  input logic       out_span_error,
  input logic       out_cal_invalid
);

  // Gather the result word and its held condition
  logic [9:0] out_word;
  logic       out_busy;

  assign out_word = {out_scaled_value, out_span_error, out_cal_invalid};
  assign out_busy = out_valid && out_stall;

  // a held result word keeps its value
  `TPAS_ASSERT_NXT(a_out_hold, out_busy, out_valid && $stable(out_word), "held word changed")

  // with the output free to move, the input side never stalls
  `TPAS_ASSERT_IMP(a_in_free, !out_busy, !in_stall, "input stalled while output drains")

  // reset empties the pipeline
  `TPAS_ASSERT_RST_NXT(a_rst_empty, !rst_n, !out_valid, "result valid right after reset")

endmodule

bind three_point_axis_scaler_core tpas_checker u_tpas_checker (.*);

// ===== sim/three_point_axis_scaler_core_checker.sv =====
// Checker for the three-point axis scaler: snoops the register port, predicts
// each result word from the accepted samples and compares in arrival order.
// Depends on tpas_pkg for widths, register codes and reset values.
`timescale 1ns / 100ps

module three_point_axis_scaler_core_checker
  import tpas_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [DATA_W-1:0] cfg_wdata,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [DATA_W-1:0] in_raw_sample,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [DATA_W-1:0] out_scaled_value,
  input  logic              out_span_error,
  input  logic              out_cal_invalid,
  output int                mismatch_count,
  output int                words_pending
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [DATA_W-1:0] scaled_value;
    logic              span_error;
    logic              cal_invalid;
  } axis_word_t;

  // Calibration as the block should hold it
  logic [DATA_W-1:0] cal_low, cal_center, cal_high, out_center, out_max;

  axis_word_t predicted_words[$];
  axis_word_t want, got;
  int         words_seen;

  // Pick the side by sign, scale by its span, clamp to 0..out_max
  function automatic axis_word_t scale_sample(input logic [DATA_W-1:0] raw);
    axis_word_t w;
    int offset, down_span, up_span, oc, level;
    offset    = int'(raw) - int'(cal_center);
    down_span = int'(cal_low) - int'(cal_center);
    up_span   = int'(cal_high) - int'(cal_center);
    oc        = int'(out_center);
    level     = oc;
    w.span_error = 1'b0;
    if (offset != 0) begin
      if ((offset < 0) == (down_span < 0)) begin
        if (down_span == 0) w.span_error = 1'b1;
        else level = oc - (oc * offset) / down_span;
      end else begin
        if (up_span == 0) w.span_error = 1'b1;
        else level = oc + ((int'(out_max) - oc) * offset) / up_span;
      end
    end
    if (level < 0) level = 0;
    else if (level > int'(out_max)) level = int'(out_max);
    w.scaled_value = level[DATA_W-1:0];
    w.cal_invalid  = !((cal_low < cal_center && cal_center < cal_high) ||
                       (cal_low > cal_center && cal_center > cal_high));
    return w;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      // Load the calibration defaults and drop anything in flight
      cal_low    = RST_CAL_LOW;
      cal_center = RST_CAL_CENTER;
      cal_high   = RST_CAL_HIGH;
      out_center = RST_OUT_CENTER;
      out_max    = RST_OUT_MAX;
      predicted_words.delete();
    end else begin
      // Compare a delivered word with the oldest prediction
      if (out_valid && !out_stall) begin
        got = '{out_scaled_value, out_span_error, out_cal_invalid};
        if (predicted_words.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("%0t: unexpected word: value %0d span_error %b cal_invalid %b",
                     $realtime, got.scaled_value, got.span_error, got.cal_invalid);
          mismatch_count++;
        end else begin
          want = predicted_words.pop_front();
          if (got !== want) begin
            if (mismatch_count < REPORT_LIMIT) begin
              $write("%0t: word %0d mismatch: expected %0d span_error %b cal_invalid %b",
                     $realtime, words_seen, want.scaled_value, want.span_error,
                     want.cal_invalid);
              $display(", got %0d span_error %b cal_invalid %b",
                       got.scaled_value, got.span_error, got.cal_invalid);
            end
            mismatch_count++;
          end
        end
        words_seen++;
      end
      // Predict the result of an accepted sample
      if (in_valid && !in_stall)
        predicted_words.push_back(scale_sample(in_raw_sample));
      // Track register writes; indexes past the last register do nothing
      if (cfg_we) begin
        case (cfg_index)
          REG_CAL_LOW:    cal_low    = cfg_wdata;
          REG_CAL_CENTER: cal_center = cfg_wdata;
          REG_CAL_HIGH:   cal_high   = cfg_wdata;
          REG_OUT_CENTER: out_center = cfg_wdata;
          REG_OUT_MAX:    out_max    = cfg_wdata;
          default: ;
        endcase
      end
    end
    words_pending = predicted_words.size();
  end

endmodule

// ===== sim/three_point_axis_scaler_core_test.sv =====
// Top of the axis scaler testbench: clock, reset, register writes, sample
// stimulus and receiver stalls. Needs the core, tpas_pkg and the checker.
`timescale 1ns / 100ps

module three_point_axis_scaler_core_test;
  import tpas_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int LONG_HOLD      = 60;
  localparam int PRESSURE_ITEMS = 30;
  localparam int RANDOM_PHASES  = 20;
  localparam int PHASE_ITEMS    = 96;
  localparam int TAIL_CYCLES    = 16;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [2:0]        cfg_index;
  logic [DATA_W-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic [DATA_W-1:0] in_raw_sample;
  logic              out_valid;
  logic              out_stall;
  logic [DATA_W-1:0] out_scaled_value;
  logic              out_span_error;
  logic              out_cal_invalid;
  int                mismatch_count;
  int                words_pending;

  // Idling controls shared with the receiver
  logic tx_gaps, rx_stalls, hold_off_req;
  // Calibration last written, used to aim samples at the break points
  logic [DATA_W-1:0] cur_low, cur_center, cur_high;

  three_point_axis_scaler_core i_dut (.*);

  three_point_axis_scaler_core_checker i_checker (.*);

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Hard stop for a hung run
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off once requested
  initial begin : receiver
    int r;
    int stall_left;
    bit hold_done;
    out_stall  = 1'b0;
    stall_left = 0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = 0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (!rx_stalls) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          stall_left = (r < 97) ? $urandom_range(0, 3) : $urandom_range(10, 40);
        end
      end
    end
  end

  function automatic int tx_gap();
    int r;
    if (!tx_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Write one register; enable goes high at the next falling edge after the call
  task automatic write_reg(input logic [2:0] index, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_cal(input logic [DATA_W-1:0] lo, ce, hi, oc, om);
    write_reg(REG_CAL_LOW, lo);
    write_reg(REG_CAL_CENTER, ce);
    write_reg(REG_CAL_HIGH, hi);
    write_reg(REG_OUT_CENTER, oc);
    write_reg(REG_OUT_MAX, om);
    cur_low    = lo;
    cur_center = ce;
    cur_high   = hi;
  endtask

  // Offer one sample at a falling edge and hold it until taken
  task automatic send_sample(input logic [DATA_W-1:0] raw);
    int n;
    in_valid      <= 1'b1;
    in_raw_sample <= raw;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    n = tx_gap();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Drop valid and wait until every predicted word has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
  endtask

  // Mostly random, biased toward the calibration points and the extremes
  function automatic logic [DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return cur_center;
      1: return cur_low;
      2: return cur_high;
      3: return {DATA_W{1'($urandom)}};
      4: return $urandom_range(0, 1) ? cur_center + DATA_W'($urandom_range(1, 3))
                                     : cur_center - DATA_W'($urandom_range(1, 3));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Choose a calibration for one random phase
  task automatic random_cal();
    logic [DATA_W-1:0] a, b, c, oc, om;
    oc = DATA_W'($urandom);
    om = DATA_W'($urandom);
    case ($urandom_range(0, 9))
      5, 6: begin
        // ordered triple, either wiring direction
        a = DATA_W'($urandom_range(0, 85));
        b = a + DATA_W'($urandom_range(1, 85));
        c = b + DATA_W'($urandom_range(1, 84));
        if ($urandom_range(0, 1)) set_cal(a, b, c, oc, om);
        else set_cal(c, b, a, oc, om);
      end
      7: begin
        // center on one extreme: zero span on that side
        a = DATA_W'($urandom);
        b = DATA_W'($urandom);
        if ($urandom_range(0, 1)) set_cal(a, a, b, oc, om);
        else set_cal(a, b, b, oc, om);
      end
      8: set_cal({DATA_W{1'($urandom)}}, {DATA_W{1'($urandom)}}, {DATA_W{1'($urandom)}},
                 {DATA_W{1'($urandom)}}, {DATA_W{1'($urandom)}});
      9: begin
        // output center above output max
        om = DATA_W'($urandom_range(0, 200));
        oc = om + DATA_W'($urandom_range(1, 255 - int'(om)));
        set_cal(DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom), oc, om);
      end
      default: set_cal(DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom), oc, om);
    endcase
  endtask

  // Stimulus and verdict
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_raw_sample = '0;
    tx_gaps       = 1'b1;
    rx_stalls     = 1'b1;
    hold_off_req  = 1'b0;
    cur_low       = RST_CAL_LOW;
    cur_center    = RST_CAL_CENTER;
    cur_high      = RST_CAL_HIGH;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset calibration: extremes and both sides of the center
    send_sample(8'd0);
    send_sample(8'd128);
    send_sample(8'd255);
    send_sample(8'd127);
    send_sample(8'd129);
    drain();

    // Reversed wiring
    set_cal(8'd255, 8'd128, 8'd0, 8'd128, 8'd255);
    send_sample(8'd0);
    send_sample(8'd255);
    send_sample(8'd128);
    send_sample(8'd64);
    drain();

    // Low span zero, sample on the low side
    set_cal(8'd100, 8'd100, 8'd200, 8'd128, 8'd255);
    send_sample(8'd150);
    send_sample(8'd50);
    send_sample(8'd100);
    drain();

    // High span zero, sample on the high side
    set_cal(8'd50, 8'd200, 8'd200, 8'd128, 8'd255);
    send_sample(8'd255);
    send_sample(8'd10);
    drain();

    // Output center above output max
    set_cal(8'd0, 8'd128, 8'd255, 8'd200, 8'd50);
    send_sample(8'd128);
    send_sample(8'd0);
    send_sample(8'd255);
    send_sample(8'd200);
    drain();

    // All registers at each extreme
    set_cal(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_sample(8'd0);
    send_sample(8'd255);
    drain();
    set_cal(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_sample(8'd0);
    send_sample(8'd255);
    drain();

    // Writes to unused indexes must leave the calibration alone
    for (int i = int'(REG_OUT_MAX) + 1; i < (1 << $bits(cfg_index)); i++)
      write_reg(3'(i), DATA_W'($urandom));
    send_sample(8'd0);
    drain();

    // Back-to-back samples into a long output hold-off
    set_cal(8'd20, 8'd120, 8'd230, 8'd100, 8'd240);
    tx_gaps      = 1'b0;
    hold_off_req = 1'b1;
    repeat (PRESSURE_ITEMS) send_sample(pick_sample());
    drain();

    // Random phases with varied calibration and idling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_cal();
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) send_sample(pick_sample());
      drain();
    end

    // Let any stray word show up before the verdict
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && words_pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
